// ===== hw/rtl/phl_pkg.sv =====
`default_nettype none

package phl_pkg;

    // default text size limit
    localparam int unsigned MAX_TEXT_BYTES_DEF = 65535;

    // result field widths
    localparam int unsigned POS_W    = 16;
    localparam int unsigned STATUS_W = 2;
    localparam int unsigned CHAR_W   = 8;

    // character codes
    localparam logic [CHAR_W-1:0] CH_DASH    = 8'h2D;
    localparam logic [CHAR_W-1:0] CH_NEWLINE = 8'h0A;
    localparam logic [CHAR_W-1:0] CH_TAB     = 8'h09;
    localparam logic [CHAR_W-1:0] CH_SPACE   = 8'h20;
    localparam logic [CHAR_W-1:0] CH_NUL     = 8'h00;

    // result status codes
    localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NO_SEP   = 2'd1;
    localparam logic [STATUS_W-1:0] ST_NO_TITLE = 2'd2;
    localparam logic [STATUS_W-1:0] ST_TOO_LONG = 2'd3;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [POS_W-1:0]    body_start;
        logic [POS_W-1:0]    picture_length;
        logic [POS_W-1:0]    picture_start;
        logic [POS_W-1:0]    title_length;
        logic [POS_W-1:0]    title_start;
    } result_t;

endpackage

`default_nettype wire

// ===== hw/rtl/post_header_locator.sv =====
`default_nettype none

// channel | dir | tdata (low bits first)                    | tuser  | tlast
// --------+-----+-------------------------------------------+--------+--------------------
// s_axis  | in  | char_value                                | -      | is_end (no byte)
// m_axis  | out | title start+len, picture start+len, body  | status | -
//
// one input beat per cycle while s_tready is high; each text byte is folded into the scan registers as it is taken
// the end beat builds the result combinationally and loads it into the output register,
// so m_tvalid rises in the next cycle unless an earlier result is still held there
// a held result parks the next one in the skid entry; s_tready drops only while it is full
// synchronous active-low reset clears the scan state and both result entries

module post_header_locator #(
    parameter int unsigned MAX_TEXT_BYTES = phl_pkg::MAX_TEXT_BYTES_DEF
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // s_tdata: [7:0] char_value
    input  wire logic [7:0]  s_tdata,
    input  wire logic        s_tlast,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // m_tdata: [15:0] title_start, [31:16] title_length, [47:32] picture_start,
    //          [63:48] picture_length, [79:64] body_start
    output logic [79:0]      m_tdata,
    // m_tuser: [1:0] status
    output logic [1:0]       m_tuser,
    output logic             m_tvalid,
    input  wire logic        m_tready
);

    import phl_pkg::*;

    // saturating byte counter holds up to MAX_TEXT_BYTES + 1
    localparam int unsigned OFS_W = $clog2(MAX_TEXT_BYTES + 2);

    typedef enum logic [2:0] {
        PH_LEAD,    // leading blanks of a line
        PH_DASH,    // inside a dash run
        PH_TAIL,    // blanks after three or more dashes
        PH_REST,    // plain line content
        PH_BODY,    // after separator, looking for the body
        PH_DONE,    // body found, only counting
        PH_HALT     // text ended by a zero byte
    } phase_t;

    // scan state
    logic [OFS_W-1:0] byte_offset_reg, byte_offset_next;
    phase_t           phase_reg, phase_next;
    logic [1:0]       dash_count_reg, dash_count_next;
    logic [POS_W-1:0] line_first_reg, line_first_next;
    logic [POS_W-1:0] line_last_reg, line_last_next;
    logic             line_has_reg, line_has_next;
    logic [1:0]       lines_taken_reg, lines_taken_next;
    logic [POS_W-1:0] title_begin_reg, title_begin_next;
    logic [POS_W-1:0] title_last_reg, title_last_next;
    logic [POS_W-1:0] picture_begin_reg, picture_begin_next;
    logic [POS_W-1:0] picture_last_reg, picture_last_next;
    logic [POS_W-1:0] region_end_reg, region_end_next;
    logic             sep_seen_reg, sep_seen_next;
    logic [POS_W-1:0] body_offset_reg, body_offset_next;

    // result buffer: output register plus one skid entry
    result_t out_reg, skid_reg;
    logic    out_valid_reg, skid_valid_reg;

    logic             in_fire;
    logic             end_fire;
    logic [OFS_W+POS_W-1:0] ofs_wide;
    logic [POS_W-1:0] pos;
    logic             blank, newline, content, not_full;

    // state as left by end-of-text handling
    logic             fin_sep;
    logic             fin_body_here;
    logic [POS_W-1:0] fin_body;
    result_t          res;

    assign s_tready = !skid_valid_reg;
    assign in_fire  = s_tvalid && s_tready;
    assign end_fire = in_fire && s_tlast;

    // low bits of the offset, zero extended when the counter is narrow
    assign ofs_wide = {{POS_W{1'b0}}, byte_offset_reg};
    assign pos      = ofs_wide[POS_W-1:0];
    assign not_full = (byte_offset_reg <= OFS_W'(MAX_TEXT_BYTES));

    assign blank   = (s_tdata == CH_SPACE) || (s_tdata == CH_TAB);
    assign newline = (s_tdata == CH_NEWLINE);

    // end of text: a pending dash line becomes the separator, body at the end
    always_comb begin
        fin_sep       = sep_seen_reg;
        fin_body_here = 1'b0;
        if (phase_reg != PH_HALT) begin
            if ((phase_reg == PH_DASH && dash_count_reg == 2'd3) ||
                phase_reg == PH_TAIL) begin
                fin_sep       = 1'b1;
                fin_body_here = 1'b1;
            end else if (phase_reg == PH_BODY) begin
                fin_body_here = 1'b1;
            end
        end
        fin_body = fin_body_here ? pos : body_offset_reg;
    end

    // result assembly
    always_comb begin
        res = '0;
        if (!not_full) begin
            res.status = ST_TOO_LONG;
        end else if (!fin_sep) begin
            res.status = ST_NO_SEP;
        end else if (lines_taken_reg == 2'd0) begin
            res.status     = ST_NO_TITLE;
            res.body_start = fin_body;
        end else begin
            res.status       = ST_OK;
            res.title_start  = title_begin_reg;
            res.title_length = title_last_reg - title_begin_reg + POS_W'(1);
            if (lines_taken_reg == 2'd2) begin
                res.picture_start  = picture_begin_reg;
                res.picture_length = picture_last_reg - picture_begin_reg + POS_W'(1);
            end else begin
                res.picture_start  = region_end_reg;
                res.picture_length = '0;
            end
            res.body_start = fin_body;
        end
    end

    // per-byte scan
    always_comb begin
        byte_offset_next   = byte_offset_reg;
        phase_next         = phase_reg;
        dash_count_next    = dash_count_reg;
        line_first_next    = line_first_reg;
        line_last_next     = line_last_reg;
        line_has_next      = line_has_reg;
        lines_taken_next   = lines_taken_reg;
        title_begin_next   = title_begin_reg;
        title_last_next    = title_last_reg;
        picture_begin_next = picture_begin_reg;
        picture_last_next  = picture_last_reg;
        region_end_next    = region_end_reg;
        sep_seen_next      = sep_seen_reg;
        body_offset_next   = body_offset_reg;
        content            = 1'b0;

        if (end_fire) begin
            // back to the reset state for the next text
            byte_offset_next   = '0;
            phase_next         = PH_LEAD;
            dash_count_next    = '0;
            line_first_next    = '0;
            line_last_next     = '0;
            line_has_next      = 1'b0;
            lines_taken_next   = '0;
            title_begin_next   = '0;
            title_last_next    = '0;
            picture_begin_next = '0;
            picture_last_next  = '0;
            region_end_next    = '0;
            sep_seen_next      = 1'b0;
            body_offset_next   = '0;
        end else if (in_fire && phase_reg != PH_HALT) begin
            if (s_tdata == CH_NUL) begin
                // zero byte ends the text early
                sep_seen_next    = fin_sep;
                body_offset_next = fin_body;
                phase_next       = PH_HALT;
            end else begin
                content = (phase_reg inside {PH_LEAD, PH_DASH, PH_TAIL, PH_REST}) &&
                          !newline && !blank;
                if (content) begin
                    if (!line_has_reg) begin
                        line_has_next   = 1'b1;
                        line_first_next = pos;
                    end
                    line_last_next = pos;
                end

                case (phase_reg)
                    PH_LEAD: begin
                        if (s_tdata == CH_DASH) begin
                            dash_count_next = 2'd1;
                            phase_next      = PH_DASH;
                        end else if (!newline && !blank) begin
                            phase_next = PH_REST;
                        end
                    end
                    PH_DASH: begin
                        if (s_tdata == CH_DASH) begin
                            if (dash_count_reg != 2'd3) begin
                                dash_count_next = dash_count_reg + 2'd1;
                            end
                        end else if (newline) begin
                            if (dash_count_reg == 2'd3) begin
                                sep_seen_next = 1'b1;
                                phase_next    = PH_BODY;
                            end
                        end else if (blank && dash_count_reg == 2'd3) begin
                            phase_next = PH_TAIL;
                        end else begin
                            phase_next = PH_REST;
                        end
                    end
                    PH_TAIL: begin
                        if (newline) begin
                            sep_seen_next = 1'b1;
                            phase_next    = PH_BODY;
                        end else if (!blank) begin
                            phase_next = PH_REST;
                        end
                    end
                    PH_BODY: begin
                        if (!newline && !blank) begin
                            body_offset_next = pos;
                            phase_next       = PH_DONE;
                        end
                    end
                    default: begin
                    end
                endcase

                // newline on a line that is not the separator closes it
                if (newline && (phase_reg == PH_LEAD || phase_reg == PH_REST ||
                    (phase_reg == PH_DASH && dash_count_reg != 2'd3))) begin
                    if (line_has_reg) begin
                        if (lines_taken_reg == 2'd0) begin
                            title_begin_next = line_first_reg;
                            title_last_next  = line_last_reg;
                            lines_taken_next = 2'd1;
                        end else if (lines_taken_reg == 2'd1) begin
                            picture_begin_next = line_first_reg;
                            picture_last_next  = line_last_reg;
                            lines_taken_next   = 2'd2;
                        end
                    end
                    region_end_next = pos;
                    line_has_next   = 1'b0;
                    line_first_next = '0;
                    line_last_next  = '0;
                    dash_count_next = '0;
                    phase_next      = PH_LEAD;
                end

                if (not_full) begin
                    byte_offset_next = byte_offset_reg + OFS_W'(1);
                end
            end
        end
    end

    // scan state and result buffer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            byte_offset_reg   <= '0;
            phase_reg         <= PH_LEAD;
            dash_count_reg    <= '0;
            line_first_reg    <= '0;
            line_last_reg     <= '0;
            line_has_reg      <= 1'b0;
            lines_taken_reg   <= '0;
            title_begin_reg   <= '0;
            title_last_reg    <= '0;
            picture_begin_reg <= '0;
            picture_last_reg  <= '0;
            region_end_reg    <= '0;
            sep_seen_reg      <= 1'b0;
            body_offset_reg   <= '0;
            out_reg           <= '0;
            skid_reg          <= '0;
            out_valid_reg     <= 1'b0;
            skid_valid_reg    <= 1'b0;
        end else begin
            byte_offset_reg   <= byte_offset_next;
            phase_reg         <= phase_next;
            dash_count_reg    <= dash_count_next;
            line_first_reg    <= line_first_next;
            line_last_reg     <= line_last_next;
            line_has_reg      <= line_has_next;
            lines_taken_reg   <= lines_taken_next;
            title_begin_reg   <= title_begin_next;
            title_last_reg    <= title_last_next;
            picture_begin_reg <= picture_begin_next;
            picture_last_reg  <= picture_last_next;
            region_end_reg    <= region_end_next;
            sep_seen_reg      <= sep_seen_next;
            body_offset_reg   <= body_offset_next;

            if (!out_valid_reg || m_tready) begin
                if (skid_valid_reg) begin
                    out_valid_reg  <= 1'b1;
                    skid_valid_reg <= end_fire;
                    out_reg        <= skid_reg;
                    if (end_fire) begin
                        skid_reg <= res;
                    end
                end else begin
                    out_valid_reg <= end_fire;
                    if (end_fire) begin
                        out_reg <= res;
                    end
                end
            end else if (end_fire) begin
                skid_valid_reg <= 1'b1;
                skid_reg       <= res;
            end
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_reg.status;
    assign m_tdata  = {out_reg.body_start, out_reg.picture_length, out_reg.picture_start,
                       out_reg.title_length, out_reg.title_start};

    // skid entry is only ever filled behind a held output
    a_skid_behind_out: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid entry valid with empty output register");

    // after an end beat the output register always holds a valid result in the next cycle
    a_end_gives_result: assert property (@(posedge aclk) disable iff (!aresetn)
        end_fire |=> out_valid_reg)
        else $error("end beat produced no result");

    // scan state restarts after each end beat
    a_restart: assert property (@(posedge aclk) disable iff (!aresetn)
        end_fire |=> (byte_offset_reg == '0 && phase_reg == PH_LEAD && !sep_seen_reg))
        else $error("scan state not cleared after end beat");

    // byte counter saturates one past the limit
    a_offset_sat: assert property (@(posedge aclk) disable iff (!aresetn)
        byte_offset_reg <= OFS_W'(MAX_TEXT_BYTES + 1))
        else $error("byte offset beyond saturation point");

    // body search only starts once a separator is seen
    a_body_after_sep: assert property (@(posedge aclk) disable iff (!aresetn)
        (phase_reg == PH_BODY || phase_reg == PH_DONE) |-> sep_seen_reg)
        else $error("body phase without separator");

endmodule

`default_nettype wire
